@@ rtl/mipfm_pkg.sv @@
`timescale 1ns / 1ps

package mipfm_pkg;

	// Configuration register widths and indexes
	localparam int CAP_W = 7;
	localparam int LEN_W = 7;
	localparam int THR_W = 12;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_PKT_LEN  = 1'b1;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;
	localparam logic [LEN_W-1:0] PKT_LEN_RESET  = 7'd8;

	// Request kinds carried in the lowest tuser bit
	localparam logic REQ_ENQ  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic enq;     // store an enqueue request, load its result
		logic tick;    // pick a port, pop its head, issue the memory read
		logic finish;  // read data is back: update lock, load the tick result
	} mipfm_cmd_t;

endpackage

@@ rtl/mipfm_ctrl.sv @@
`timescale 1ns / 1ps

module mipfm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  req_type,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output mipfm_pkg::mipfm_cmd_t cmd
);
	import mipfm_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic slot_free;
	logic accept;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_TICK) begin
						cmd.tick = 1'b1;
						state_d  = S_READ;
					end else begin
						cmd.enq = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.enq || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/mipfm_dp.sv @@
`timescale 1ns / 1ps

module mipfm_dp #(
	parameter int NUM_PORTS    = 4,
	parameter int MAX_CAPACITY = 64,
	parameter int FLIT_WIDTH   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mipfm_pkg::mipfm_cmd_t        cmd,
	input  logic                         wr_en,
	input  logic                         wr_index,
	input  logic [mipfm_pkg::CAP_W-1:0]  wr_data,
	input  logic [1:0]                   in_port,
	input  logic [FLIT_WIDTH-1:0]        in_data,
	input  logic                         in_last,
	output logic                         out_valid,
	output logic [FLIT_WIDTH-1:0]        out_data,
	output logic                         out_last,
	output logic [1:0]                   out_port,
	output logic                         overflow,
	output logic                         stop_inputs,
	output logic                         bubble_ready,
	output logic [mipfm_pkg::CAP_W-1:0]  free_slots
);
	import mipfm_pkg::*;

	localparam int PW      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int PTR_W   = $clog2(MAX_CAPACITY);
	localparam int DEPTH   = NUM_PORTS << PTR_W;
	localparam int CAP_LIM = (MAX_CAPACITY > 127) ? 127 : MAX_CAPACITY;

	logic [FLIT_WIDTH:0] mem [DEPTH];
	logic [FLIT_WIDTH:0] rd_q;

	logic [CAP_W-1:0] capacity_q;
	logic [LEN_W-1:0] pkt_len_q;

	logic [PTR_W-1:0] head_q  [NUM_PORTS];
	logic [PTR_W-1:0] tail_q  [NUM_PORTS];
	logic [CAP_W-1:0] count_q [NUM_PORTS];
	logic [CAP_W-1:0] total_q;
	logic             locked_q;
	logic [PW-1:0]    lport_q;
	logic             stop_q;
	logic             found_s1;
	logic [PW-1:0]    sel_s1;

	logic [NUM_PORTS-1:0] nonempty;
	logic             port_ok;
	logic [PW-1:0]    enq_port;
	logic [CAP_W-1:0] cap_eff;
	logic [CAP_W-1:0] free_now;
	logic [CAP_W-1:0] total_next;
	logic [CAP_W-1:0] free_next;
	logic [THR_W-1:0] thr;
	logic             enq_do;
	logic             enq_ovf;
	logic             pick_found;
	logic [PW-1:0]    pick_sel;
	logic             pop_do;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(MAX_CAPACITY - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_PORTS; i++) begin
			nonempty[i] = (count_q[i] != '0);
		end

		port_ok  = (int'(in_port) < NUM_PORTS);
		enq_port = PW'(in_port);
		cap_eff  = (capacity_q > CAP_W'(CAP_LIM)) ? CAP_W'(CAP_LIM) : capacity_q;
		free_now = (cap_eff > total_q) ? cap_eff - total_q : '0;
		enq_do   = cmd.enq && port_ok && (free_now != '0);
		enq_ovf  = cmd.enq && port_ok && (free_now == '0);

		// locked packet keeps its port, else lowest nonempty port wins
		pick_found = 1'b0;
		pick_sel   = '0;
		if (locked_q) begin
			pick_found = nonempty[lport_q];
			pick_sel   = lport_q;
		end else begin
			for (int i = NUM_PORTS - 1; i >= 0; i--) begin
				if (nonempty[i]) begin
					pick_found = 1'b1;
					pick_sel   = PW'(i);
				end
			end
		end
		pop_do = cmd.tick && pick_found;

		if (enq_do) begin
			total_next = total_q + CAP_W'(1);
		end else if (pop_do) begin
			total_next = total_q - CAP_W'(1);
		end else begin
			total_next = total_q;
		end
		free_next = (cap_eff > total_next) ? cap_eff - total_next : '0;
		thr       = THR_W'(NUM_PORTS + 1) * THR_W'(pkt_len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			pkt_len_q  <= PKT_LEN_RESET;
			for (int i = 0; i < NUM_PORTS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			total_q  <= '0;
			locked_q <= 1'b0;
			lport_q  <= '0;
			stop_q   <= 1'b0;
			found_s1 <= 1'b0;
			sel_s1   <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_CAPACITY: capacity_q <= wr_data;
					REG_PKT_LEN:  pkt_len_q  <= wr_data;
					default: ;
				endcase
			end
			total_q <= total_next;
			for (int i = 0; i < NUM_PORTS; i++) begin
				if (enq_do && enq_port == PW'(i)) begin
					tail_q[i]  <= advance(tail_q[i]);
					count_q[i] <= count_q[i] + CAP_W'(1);
				end else if (pop_do && pick_sel == PW'(i)) begin
					head_q[i]  <= advance(head_q[i]);
					count_q[i] <= count_q[i] - CAP_W'(1);
				end
			end
			if (cmd.tick) begin
				found_s1 <= pick_found;
				sel_s1   <= pick_sel;
				stop_q   <= {{(THR_W - CAP_W){1'b0}}, free_next} <= thr;
			end
			if (cmd.finish && found_s1) begin
				locked_q <= !rd_q[FLIT_WIDTH];
				lport_q  <= sel_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq_do) begin
			mem[{enq_port, tail_q[enq_port]}] <= {in_last, in_data};
		end
		if (pop_do) begin
			rd_q <= mem[{pick_sel, head_q[pick_sel]}];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.enq || cmd.finish) begin
			out_valid    <= cmd.finish && found_s1;
			out_data     <= (cmd.finish && found_s1) ? rd_q[FLIT_WIDTH-1:0] : '0;
			out_last     <= cmd.finish && found_s1 && rd_q[FLIT_WIDTH];
			out_port     <= (cmd.finish && found_s1) ? 2'(sel_s1) : 2'b00;
			overflow     <= enq_ovf;
			stop_inputs  <= stop_q;
			bubble_ready <= {{(THR_W - CAP_W){1'b0}}, free_next} >= thr;
			free_slots   <= free_next;
		end
	end

endmodule

@@ rtl/multi_input_packet_fifo_merger_unit.sv @@
`timescale 1ns / 1ps

// Multi-input packet FIFO merger: one flit queue per input port, all
// sharing one pool of buffer_capacity slots held in a single memory.
// Slave channel: tuser = {in_port, req_type}; req_type 0 enqueues the flit
// in tdata (tlast marks a packet tail), req_type 1 is an output tick.
// Master channel: one result per request. tuser = {out_port, out_valid},
// tlast = out_last, tdata = {free_slots, bubble_ready, stop_inputs,
// overflow, out_data}. A tick sends the locked port's head flit, or the
// lowest nonempty port's when no packet is locked.
// An enqueue result is registered in the cycle after acceptance; a tick
// result passes the registered read port of the queue memory and then the
// result register. Up to one enqueue per cycle while the output register
// is free; no new request is taken while a tick read is outstanding.
// Reset clears all queues, the lock and the stop flag; capacity returns to
// 64 and packet length to 8. Memory contents need no clearing.
// The result sits in an output register; while the receiver stalls it
// holds, and a new request is taken only once that register is free or
// being emptied in the same cycle. The user must write configuration
// (wr_en, wr_index, wr_data) only while idle; the block does not enforce it.

module multi_input_packet_fifo_merger_unit #(
	parameter int NUM_PORTS    = 4,
	parameter int MAX_CAPACITY = 64,
	parameter int FLIT_WIDTH   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic                                   wr_index,
	input  logic [mipfm_pkg::CAP_W-1:0]            wr_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((FLIT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // in_data
	input  logic [2:0]                             s_tuser,   // req_type, in_port
	input  logic                                   s_tlast,   // in_last
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// out_data, overflow, stop_inputs, bubble_ready, free_slots
	output logic [((FLIT_WIDTH + 17) / 8) * 8 - 1:0] m_tdata,
	output logic [2:0]                             m_tuser,   // out_valid, out_port
	output logic                                   m_tlast    // out_last
);
	import mipfm_pkg::*;

	localparam int OUT_W = FLIT_WIDTH + 3 + CAP_W;
	localparam int M_W   = ((FLIT_WIDTH + 17) / 8) * 8;

	mipfm_cmd_t cmd;

	logic                  out_valid;
	logic [FLIT_WIDTH-1:0] out_data;
	logic                  out_last;
	logic [1:0]            out_port;
	logic                  overflow;
	logic                  stop_inputs;
	logic                  bubble_ready;
	logic [CAP_W-1:0]      free_slots;

	mipfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser[0]),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	mipfm_dp #(
		.NUM_PORTS    (NUM_PORTS),
		.MAX_CAPACITY (MAX_CAPACITY),
		.FLIT_WIDTH   (FLIT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_port      (s_tuser[2:1]),
		.in_data      (s_tdata[FLIT_WIDTH-1:0]),
		.in_last      (s_tlast),
		.out_valid    (out_valid),
		.out_data     (out_data),
		.out_last     (out_last),
		.out_port     (out_port),
		.overflow     (overflow),
		.stop_inputs  (stop_inputs),
		.bubble_ready (bubble_ready),
		.free_slots   (free_slots)
	);

	assign m_tdata = {{(M_W - OUT_W){1'b0}}, free_slots, bubble_ready, stop_inputs,
		overflow, out_data};
	assign m_tuser = {out_port, out_valid};
	assign m_tlast = out_last;

	// tick result loads only into an empty output register
	a_finish_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !m_tvalid)
		else $error("tick result would overwrite a pending result");

	// no new request while a tick read is outstanding
	a_finish_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !s_tready)
		else $error("request accepted during tick read");

	// every accepted tick completes on the next cycle
	a_tick_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == REQ_TICK) |=> (cmd.finish && !$past(cmd.enq)))
		else $error("tick did not complete");

	// an accepted enqueue shows its result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == REQ_ENQ) |=> m_tvalid)
		else $error("enqueue result missing");

endmodule
